>>> design/stcbs_pkg.sv
// Package for the stable three-class bucket sort: sizes, codes, word and state types.
`default_nettype none

package stcbs_pkg;

  localparam int CAPACITY    = 64;
  localparam int NUM_W       = 32;
  localparam int COLOR_W     = 2;
  localparam int BUCKETS     = 3;
  localparam int BKT_W       = 2;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int ADDR_W      = BKT_W + IDX_W;
  localparam int STORE_W     = NUM_W + COLOR_W;
  localparam int STORE_DEPTH = BUCKETS * CAPACITY;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_BLUE   = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_OTHER  = 2'd3;

  typedef enum logic [BKT_W-1:0] {
    BKT_RED  = 2'd0,
    BKT_BLUE = 2'd1,
    BKT_REST = 2'd2
  } bucket_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] number;
    logic [COLOR_W-1:0]      color;
    bucket_t                 bucket;
    logic                    last;
  } item_word_t;

  function automatic bucket_t bucket_of(logic [COLOR_W-1:0] color);
    bucket_t b;
    case (color)
      COLOR_RED:  b = BKT_RED;
      COLOR_BLUE: b = BKT_BLUE;
      default:    b = BKT_REST;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/stcbs_in_if.sv
// Input channel interface: valid, ready and the fields of one input item.
`default_nettype none

interface stcbs_in_if
  import stcbs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] item_number;
  logic [COLOR_W-1:0]      item_color;
  logic                    last_of_set;

  modport source (output valid, output item_number, output item_color, output last_of_set,
                  input ready);
  modport sink   (input valid, input item_number, input item_color, input last_of_set,
                  output ready);
endinterface

`default_nettype wire

>>> design/stcbs_out_if.sv
// Result channel interface: valid, ready and the fields of one result item.
`default_nettype none

interface stcbs_out_if
  import stcbs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] out_number;
  logic [COLOR_W-1:0]      out_color;
  logic                    out_last;
  logic                    overflow_seen;

  modport source (output valid, output out_number, output out_color, output out_last,
                  output overflow_seen, input ready);
  modport sink   (input valid, input out_number, input out_color, input out_last,
                  input overflow_seen, output ready);
endinterface

`default_nettype wire

>>> design/stcbs_front.sv
// Front part: accepts input words, classifies them into buckets and queues them.
`default_nettype none

module stcbs_front
  import stcbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  stcbs_in_if.sink    in_chan,
  output item_word_t  q_word,
  output logic        q_valid,
  input  wire logic   q_ready
);

  item_word_t          queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push, pop;
  item_word_t          push_word;

  always_comb begin
    in_chan.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
    q_valid       = (count_r != '0);
    q_word        = queue_r[rd_ptr_r];
    push          = in_chan.valid && in_chan.ready;
    pop           = q_valid && q_ready;

    push_word.number = in_chan.item_number;
    push_word.color  = in_chan.item_color;
    push_word.bucket = bucket_of(in_chan.item_color);
    push_word.last   = in_chan.last_of_set;

    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

>>> design/stcbs_back.sv
// Back part: bucket store, per-bucket counts and the sequencer that emits a finished set.
`default_nettype none

module stcbs_back
  import stcbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire item_word_t  q_word,
  input  wire logic        q_valid,
  output logic             q_ready,
  stcbs_out_if.source      out_chan
);

  logic [STORE_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_W-1:0]      rdata_r;

  back_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r [BUCKETS];
  logic [CNT_W-1:0]        cnt_nxt [BUCKETS];
  logic                    ovf_r, ovf_nxt;
  bucket_t                 cur_b_r, cur_b_nxt;
  logic [CNT_W-1:0]        cur_k_r, cur_k_nxt;
  logic [CNT_W-1:0]        issued_r, issued_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    rd_last_r, rd_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [NUM_W-1:0] out_number_r, out_number_nxt;
  logic [COLOR_W-1:0]      out_color_r, out_color_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic [CNT_W-1:0]        total;
  logic                    out_fire, xfer;
  logic                    wr_en, rd_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [STORE_W-1:0]      wr_data;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_number    = out_number_r;
  assign out_chan.out_color     = out_color_r;
  assign out_chan.out_last      = out_last_r;
  assign out_chan.overflow_seen = out_ovf_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    cur_b_nxt      = cur_b_r;
    cur_k_nxt      = cur_k_r;
    issued_nxt     = issued_r;
    rd_pend_nxt    = rd_pend_r;
    rd_last_nxt    = rd_last_r;
    out_valid_nxt  = out_valid_r;
    out_number_nxt = out_number_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    wr_en          = 1'b0;
    wr_addr        = {q_word.bucket, cnt_r[q_word.bucket][IDX_W-1:0]};
    wr_data        = {q_word.number, q_word.color};
    rd_en          = 1'b0;
    rd_addr        = {cur_b_r, cur_k_r[IDX_W-1:0]};
    q_ready        = (state_r == ST_LOAD);
    total          = cnt_r[0] + cnt_r[1] + cnt_r[2];
    out_fire       = out_valid_r && out_chan.ready;
    xfer           = rd_pend_r && (!out_valid_r || out_chan.ready);

    case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          // The set as a whole is limited, so a bucket can never run past its own region.
          if (total < CNT_W'(CAPACITY)) begin
            wr_en                   = 1'b1;
            cnt_nxt[q_word.bucket]  = cnt_r[q_word.bucket] + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_word.last) begin
            state_nxt  = ST_EMIT;
            cur_b_nxt  = BKT_RED;
            cur_k_nxt  = '0;
            issued_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (xfer) begin
          out_valid_nxt  = 1'b1;
          out_number_nxt = rdata_r[STORE_W-1:COLOR_W];
          out_color_nxt  = rdata_r[COLOR_W-1:0];
          out_last_nxt   = rd_last_r;
          out_ovf_nxt    = ovf_r;
          rd_pend_nxt    = 1'b0;
        end else if (out_fire) begin
          out_valid_nxt = 1'b0;
        end

        // A read is issued when the read data register is free or empties this cycle.
        if ((issued_r != total) && (!rd_pend_r || xfer)) begin
          if (cur_k_r == cnt_r[cur_b_r]) begin
            // This bucket is exhausted; move on to the next one.
            cur_b_nxt = bucket_t'(cur_b_r + BKT_W'(1));
            cur_k_nxt = '0;
          end else begin
            rd_en       = 1'b1;
            cur_k_nxt   = cur_k_r + CNT_W'(1);
            issued_nxt  = issued_r + CNT_W'(1);
            rd_pend_nxt = 1'b1;
            rd_last_nxt = ((issued_r + CNT_W'(1)) == total);
          end
        end

        if (out_fire && out_last_r) begin
          state_nxt = ST_LOAD;
          for (int i = 0; i < BUCKETS; i++) begin
            cnt_nxt[i] = '0;
          end
          ovf_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      for (int i = 0; i < BUCKETS; i++) begin
        cnt_r[i] <= '0;
      end
      ovf_r       <= 1'b0;
      cur_b_r     <= BKT_RED;
      cur_k_r     <= '0;
      issued_r    <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      cur_b_r     <= cur_b_nxt;
      cur_k_r     <= cur_k_nxt;
      issued_r    <= issued_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_number_r <= out_number_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    total <= CNT_W'(CAPACITY))
    else $error("stored total exceeds capacity");

  a_last_after_all_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (issued_r == total && !rd_pend_r))
    else $error("final word shown before every entry was read");

  a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (total == '0 && !ovf_r && state_r == ST_LOAD))
    else $error("counts not cleared after the final word");

  a_read_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r || out_valid_r) |-> (state_r == ST_EMIT))
    else $error("result path busy outside emission");
`endif

endmodule

`default_nettype wire

>>> design/stable_three_class_bucket_sort.sv
// Top level of the stable three-class bucket sort: front queue and back store.
// Input words arrive on in_chan (valid/ready); each carries a number, a colour code and a
// last-of-set marker. Red words go to bucket 0, blue to bucket 1, all others to bucket 2.
// Results leave on out_chan (valid/ready): bucket 0, then 1, then 2, each in arrival order,
// with out_last on the final word and overflow_seen set on every word of a set that lost
// words because it held more than CAPACITY.
// A four-word queue separates the input from the store, so input words are accepted one
// per cycle while the queue has room, also while a set is being emitted.
// Loading writes one word per cycle into the bucket memory. Emission reads one entry per
// cycle through the registered read port while the receiver is ready, pausing to move on
// each time it leaves a bucket while words remain in a later one, at most twice per set.
// After the last word of a set is accepted, the first result passes through the queue,
// the bucket memory, the read data register and the output register; each empty bucket
// that leads the set delays it further.
// A stalled receiver holds the output register and the read data register; emission
// resumes at full rate once ready returns.
// Reset (rst_n low, synchronous) empties the queue, zeroes the counts and the overflow
// flag and drops any emission in progress. The memory is not cleared: only entries written
// in the current set are ever read.
`default_nettype none

module stable_three_class_bucket_sort
  import stcbs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  stcbs_in_if.sink     in_chan,
  stcbs_out_if.source  out_chan
);

  item_word_t q_word;
  logic       q_valid;
  logic       q_ready;

  stcbs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_word  (q_word),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  stcbs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_word   (q_word),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
